/* rtl/core/tws_pkg.sv */
// Package for the three-wire serial master: phase codes and the per-tick result record.
// Used by tws_engine and three_wire_serial_master_unit; depends on nothing.
`default_nettype none

package tws_pkg;

    localparam int unsigned BYTE_BITS = 8;
    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd2;

    // bus phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SETUP = 6'b000010,
        PH_HIGH  = 6'b000100,
        PH_LOW   = 6'b001000,
        PH_RHIGH = 6'b010000,
        PH_RLOW  = 6'b100000
    } phase_t;

    // line levels driven toward the bus
    typedef struct packed {
        logic drv;
        logic out;
        logic clk;
        logic ce;
    } lines_t;

    // what one tick reports
    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        lines_t     lines;
    } tick_res_t;

endpackage

`default_nettype wire

/* rtl/core/three_wire_serial_master_unit.sv */
// Top level of the three-wire serial master (LSB first): stream ports, config register,
// result register. Depends on tws_pkg and tws_engine.
`default_nettype none

// Usage
//   Each request on the s_ channel is one bus tick. It carries a start flag, the
//   command and write bytes, the sampled data pin, and in s_tuser the op (0 write,
//   1 read). A start is only taken while the master is idle; it then raises chip
//   enable, shifts the command out LSB first, and either sends the write byte or
//   releases the pin and collects eight bits. Every setup, clock-high and clock-low
//   phase lasts half_period ticks (0 counts as 1).
//   Each accepted request yields exactly one result request on the m_ channel with
//   the line levels after that tick, busy, a one-tick done flag and the receive byte.
//   The result is registered and appears in the cycle after the request is accepted.
//   Throughput: one request per cycle while results drain; the state update and result
//   are both formed in the single pass from engine registers to the result register.
//   Stall: while a result is held unaccepted, s_tready stays high only if m_tready
//   is high in the same cycle; otherwise the input waits and the bus state holds.
//   Reset (aresetn low, synchronous): idle, all lines low, half_period back to 2,
//   no result pending.
//   cfg_wr_en writes half_period; do it only while no transaction is running.
module three_wire_serial_master_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,    // half_period
    // tick requests in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] start_req, [8:1] command, [16:9] write_data, [17] pin_in, [23:18] zero
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,        // [0] op
    // tick results out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] chip_enable, [1] serial_clock, [2] pin_out, [3] pin_drive, [4] busy_res,
    // [5] done_res, [13:6] read_data, [15:14] zero
    output logic [15:0]      m_tdata
);
    import tws_pkg::*;

    logic [7:0] half_period_reg;
    logic       step;
    tick_res_t  res;
    logic       m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            half_period_reg <= cfg_wr_data;
        end
    end

    // take a tick whenever the result slot is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    tws_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .half_period (half_period_reg),
        .start_req   (s_tdata[0]),
        .op          (s_tuser),
        .command     (s_tdata[8:1]),
        .write_data  (s_tdata[16:9]),
        .pin_in      (s_tdata[17]),
        .res         (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= step;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_tdata_reg <= {2'b00, res.read_data, res.done_res, res.busy_res,
                            res.lines.drv, res.lines.out, res.lines.clk, res.lines.ce};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* rtl/core/tws_engine.sv */
// Bus sequencer of the three-wire serial master: phase, bit and wait counters, shifters.
// Advances one tick per step strobe. Depends on tws_pkg.
`default_nettype none

module tws_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        half_period,
    input  wire logic              start_req,
    input  wire logic              op,
    input  wire logic [7:0]        command,
    input  wire logic [7:0]        write_data,
    input  wire logic              pin_in,
    output tws_pkg::tick_res_t     res
);
    import tws_pkg::*;

    phase_t     phase_reg,      phase_next;
    logic [3:0] bit_count_reg,  bit_count_next;
    logic       byte_index_reg, byte_index_next;
    logic [7:0] tx_shift_reg,   tx_shift_next;
    logic [7:0] data_hold_reg,  data_hold_next;
    logic [7:0] rx_shift_reg,   rx_shift_next;
    logic [7:0] wait_count_reg, wait_count_next;
    logic       is_read_reg,    is_read_next;
    lines_t     lines_reg,      lines_next;
    logic       done_next;

    logic [7:0] hp;
    logic [3:0] bit_inc;
    logic [7:0] tx_shr;

    assign hp      = (half_period == 8'd0) ? 8'd1 : half_period;
    assign bit_inc = bit_count_reg + 4'd1;
    assign tx_shr  = {1'b0, tx_shift_reg[7:1]};

    always_comb begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_index_next = byte_index_reg;
        tx_shift_next   = tx_shift_reg;
        data_hold_next  = data_hold_reg;
        rx_shift_next   = rx_shift_reg;
        wait_count_next = wait_count_reg;
        is_read_next    = is_read_reg;
        lines_next      = lines_reg;
        done_next       = 1'b0;

        if (phase_reg == PH_IDLE) begin
            if (start_req) begin
                is_read_next    = op;
                tx_shift_next   = command;
                data_hold_next  = write_data;
                byte_index_next = 1'b0;
                bit_count_next  = 4'd0;
                lines_next      = '{drv: 1'b1, out: command[0], clk: 1'b0, ce: 1'b1};
                phase_next      = PH_SETUP;
                wait_count_next = hp;
            end
        end else if (wait_count_reg > 8'd1) begin
            wait_count_next = wait_count_reg - 8'd1;
        end else begin
            case (phase_reg)
                PH_SETUP: begin
                    lines_next.clk  = 1'b1;
                    phase_next      = PH_HIGH;
                    wait_count_next = hp;
                end
                PH_HIGH: begin
                    lines_next.clk  = 1'b0;
                    phase_next      = PH_LOW;
                    wait_count_next = hp;
                end
                PH_LOW: begin
                    tx_shift_next  = tx_shr;
                    bit_count_next = bit_inc;
                    if (bit_inc < 4'(BYTE_BITS)) begin
                        lines_next      = '{drv: 1'b1, out: tx_shr[0], clk: 1'b0, ce: 1'b1};
                        phase_next      = PH_SETUP;
                        wait_count_next = hp;
                    end else if (!byte_index_reg && !is_read_reg) begin
                        // command done, data byte follows
                        byte_index_next = 1'b1;
                        bit_count_next  = 4'd0;
                        tx_shift_next   = data_hold_reg;
                        lines_next      = '{drv: 1'b1, out: data_hold_reg[0], clk: 1'b0,
                                            ce: 1'b1};
                        phase_next      = PH_SETUP;
                        wait_count_next = hp;
                    end else if (!byte_index_reg) begin
                        // command done, release pin and take first read bit
                        byte_index_next = 1'b1;
                        bit_count_next  = 4'd0;
                        rx_shift_next   = {pin_in, rx_shift_reg[7:1]};
                        lines_next      = '{drv: 1'b0, out: 1'b0, clk: 1'b1, ce: 1'b1};
                        phase_next      = PH_RHIGH;
                        wait_count_next = hp;
                    end else begin
                        lines_next      = '0;
                        phase_next      = PH_IDLE;
                        wait_count_next = 8'd0;
                        bit_count_next  = 4'd0;
                        byte_index_next = 1'b0;
                        done_next       = 1'b1;
                    end
                end
                PH_RHIGH: begin
                    lines_next      = '{drv: 1'b0, out: 1'b0, clk: 1'b0, ce: 1'b1};
                    phase_next      = PH_RLOW;
                    wait_count_next = hp;
                end
                PH_RLOW: begin
                    bit_count_next = bit_inc;
                    if (bit_inc < 4'(BYTE_BITS)) begin
                        rx_shift_next   = {pin_in, rx_shift_reg[7:1]};
                        lines_next      = '{drv: 1'b0, out: 1'b0, clk: 1'b1, ce: 1'b1};
                        phase_next      = PH_RHIGH;
                        wait_count_next = hp;
                    end else begin
                        lines_next      = '0;
                        phase_next      = PH_IDLE;
                        wait_count_next = 8'd0;
                        bit_count_next  = 4'd0;
                        byte_index_next = 1'b0;
                        done_next       = 1'b1;
                    end
                end
                default: begin
                    // corrupt phase: drop back to idle quietly
                    lines_next      = '0;
                    phase_next      = PH_IDLE;
                    wait_count_next = 8'd0;
                    bit_count_next  = 4'd0;
                    byte_index_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= 4'd0;
            byte_index_reg <= 1'b0;
            tx_shift_reg   <= 8'd0;
            data_hold_reg  <= 8'd0;
            rx_shift_reg   <= 8'd0;
            wait_count_reg <= 8'd0;
            is_read_reg    <= 1'b0;
            lines_reg      <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_index_reg <= byte_index_next;
            tx_shift_reg   <= tx_shift_next;
            data_hold_reg  <= data_hold_next;
            rx_shift_reg   <= rx_shift_next;
            wait_count_reg <= wait_count_next;
            is_read_reg    <= is_read_next;
            lines_reg      <= lines_next;
        end
    end

    assign res = '{read_data: rx_shift_next,
                   done_res:  done_next,
                   busy_res:  (phase_next != PH_IDLE),
                   lines:     lines_next};

    a_drv_needs_ce: assert property (@(posedge aclk) disable iff (!aresetn)
        lines_reg.drv |-> lines_reg.ce)
        else $error("data pin driven without chip enable");

    a_clk_needs_ce: assert property (@(posedge aclk) disable iff (!aresetn)
        lines_reg.clk |-> lines_reg.ce)
        else $error("serial clock high without chip enable");

    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_IDLE) |-> (wait_count_reg != 8'd0))
        else $error("active phase with empty wait counter");

    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done_next) |=> (phase_reg == PH_IDLE && lines_reg == '0))
        else $error("done without return to idle");

endmodule

`default_nettype wire

/* sim/tws_tick_checker.sv */
// Checker for the three-wire serial master: predicts every tick result and compares it.
// Depends on tws_pkg (phase codes, line and result records).
module tws_tick_checker
    import tws_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // [0] start_req, [8:1] command, [16:9] write_data, [17] pin_in, [23:18] zero
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,        // [0] op
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // [0] chip_enable, [1] serial_clock, [2] pin_out, [3] pin_drive, [4] busy_res,
    // [5] done_res, [13:6] read_data, [15:14] zero
    input  wire logic [15:0] m_tdata,
    output int unsigned      expected_count,
    output logic             bus_busy,
    output int unsigned      fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the bus engine
    phase_t     bus_phase;
    logic [3:0] bit_cnt;
    logic       second_byte;
    logic [7:0] tx_sr;
    logic [7:0] wr_hold;
    logic [7:0] rx_sr;
    logic [7:0] hold_cnt;
    logic       rd_op;
    lines_t     lines;
    logic [7:0] half_period_q;

    tick_res_t   expected_ticks[$];
    int unsigned fails = 0;

    function automatic void drive_bit(input logic [7:0] hp);
        lines     = '{drv: 1'b1, out: tx_sr[0], clk: 1'b0, ce: 1'b1};
        bus_phase = PH_SETUP;
        hold_cnt  = hp;
    endfunction

    // shift first, then take the pin into the top bit
    function automatic void sample_bit(input logic [7:0] hp, input logic pin);
        rx_sr     = {pin, rx_sr[7:1]};
        lines     = '{drv: 1'b0, out: 1'b0, clk: 1'b1, ce: 1'b1};
        bus_phase = PH_RHIGH;
        hold_cnt  = hp;
    endfunction

    function automatic void go_idle();
        lines       = '0;
        bus_phase   = PH_IDLE;
        hold_cnt    = '0;
        bit_cnt     = '0;
        second_byte = 1'b0;
    endfunction

    function automatic tick_res_t predict_tick(input logic start, input logic op,
                                               input logic [7:0] cmd, input logic [7:0] wdata,
                                               input logic pin);
        logic [7:0] hp;
        logic       done;
        tick_res_t  res;
        hp   = (half_period_q == 8'd0) ? 8'd1 : half_period_q;
        done = 1'b0;
        if (bus_phase == PH_IDLE) begin
            if (start) begin
                rd_op       = op;
                tx_sr       = cmd;
                wr_hold     = wdata;
                second_byte = 1'b0;
                bit_cnt     = '0;
                drive_bit(hp);
            end
        end else if (hold_cnt > 8'd1) begin
            hold_cnt = hold_cnt - 8'd1;
        end else begin
            case (bus_phase)
                PH_SETUP: begin
                    lines.clk = 1'b1;
                    bus_phase = PH_HIGH;
                    hold_cnt  = hp;
                end
                PH_HIGH: begin
                    lines.clk = 1'b0;
                    bus_phase = PH_LOW;
                    hold_cnt  = hp;
                end
                PH_LOW: begin
                    tx_sr   = tx_sr >> 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BYTE_BITS) begin
                        drive_bit(hp);
                    end else if (!second_byte && !rd_op) begin
                        second_byte = 1'b1;
                        bit_cnt     = '0;
                        tx_sr       = wr_hold;
                        drive_bit(hp);
                    end else if (!second_byte) begin
                        second_byte = 1'b1;
                        bit_cnt     = '0;
                        sample_bit(hp, pin);
                    end else begin
                        go_idle();
                        done = 1'b1;
                    end
                end
                PH_RHIGH: begin
                    lines     = '{drv: 1'b0, out: 1'b0, clk: 1'b0, ce: 1'b1};
                    bus_phase = PH_RLOW;
                    hold_cnt  = hp;
                end
                PH_RLOW: begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < BYTE_BITS) begin
                        sample_bit(hp, pin);
                    end else begin
                        go_idle();
                        done = 1'b1;
                    end
                end
                default: go_idle();
            endcase
        end
        res.lines     = lines;
        res.busy_res  = (bus_phase != PH_IDLE);
        res.done_res  = done;
        res.read_data = rx_sr;
        return res;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        tick_res_t want;
        tick_res_t got;
        if (!aresetn) begin
            half_period_q = HALF_PERIOD_RESET;
            rd_op         = 1'b0;
            tx_sr         = '0;
            wr_hold       = '0;
            rx_sr         = '0;
            go_idle();
            expected_ticks.delete();
        end else begin
            // result side first: a request's own result never lands on its accept edge
            if (m_tvalid && m_tready) begin
                got = m_tdata[13:0];
                if (expected_ticks.size() == 0) begin
                    fails++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("chip_enable", want.lines.ce, got.lines.ce);
                    check_field("serial_clock", want.lines.clk, got.lines.clk);
                    check_field("pin_out", want.lines.out, got.lines.out);
                    check_field("pin_drive", want.lines.drv, got.lines.drv);
                    check_field("busy_res", want.busy_res, got.busy_res);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("tdata pad", 0, m_tdata[15:14]);
                end
            end
            // a tick taken on the write edge still runs with the old half period
            if (s_tvalid && s_tready) begin
                expected_ticks.push_back(predict_tick(s_tdata[0], s_tuser, s_tdata[8:1],
                                                      s_tdata[16:9], s_tdata[17]));
            end
            if (cfg_wr_en) begin
                half_period_q = cfg_wr_data;
            end
        end
        expected_count <= expected_ticks.size();
        bus_busy       <= (bus_phase != PH_IDLE);
        fail_count     <= fails;
    end

endmodule

/* sim/three_wire_serial_master_unit_tb.sv */
// Testbench top for three_wire_serial_master_unit: clock, reset, tick stimulus and verdict.
// Depends on the RTL (tws_pkg, the unit) and on tws_tick_checker for all result checks.
module three_wire_serial_master_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // how the sampled data pin is driven on each tick request
    typedef enum logic [1:0] {
        PIN_RANDOM,
        PIN_HIGH,
        PIN_LOW
    } pin_mode_t;

    localparam int unsigned CYCLE_LIMIT   = 800_000;
    localparam int unsigned RANDOM_ROUNDS = 4;
    localparam int unsigned ROUND_TICKS   = 40;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    // [0] start_req, [8:1] command, [16:9] write_data, [17] pin_in, [23:18] zero
    logic [23:0] s_tdata     = 24'd0;
    logic        s_tuser     = 1'b0;   // [0] op
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    // [0] chip_enable, [1] serial_clock, [2] pin_out, [3] pin_drive, [4] busy_res,
    // [5] done_res, [13:6] read_data, [15:14] zero
    logic [15:0] m_tdata;

    int unsigned expected_count;
    logic        bus_busy;
    int unsigned fail_count;
    int unsigned cycle_cnt = 0;

    pin_mode_t pin_mode = PIN_RANDOM;
    logic      calm     = 1'b0;   // no idling on either side while set

    three_wire_serial_master_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    tws_tick_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .expected_count (expected_count),
        .bus_busy       (bus_busy),
        .fail_count     (fail_count)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // hard stop in case a handshake never completes
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic pin_level();
        case (pin_mode)
            PIN_HIGH: return 1'b1;
            PIN_LOW:  return 1'b0;
            default:  return 1'(($urandom_range(0, 1)));
        endcase
    endfunction

    // One tick request. Called on a rising edge; returns on the edge that accepted it,
    // or after the random idle that follows. tvalid stays high when no idle is drawn.
    task automatic send_tick(input logic start, input logic op,
                             input logic [7:0] cmd, input logic [7:0] wdata);
        int unsigned gap;
        s_tdata  <= {6'd0, pin_level(), wdata, cmd, start};
        s_tuser  <= op;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Feed non-start ticks (random other fields, which must not be latched) until the
    // predicted engine is idle, then wait for every result to come back.
    task automatic settle_bus();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (bus_busy) begin
            send_tick(1'b0, 1'(($urandom_range(0, 1))), 8'($urandom), 8'($urandom));
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        while (expected_count != 0) @(posedge aclk);
        // results are registered in the unit; leave a little slack
        repeat (3) @(posedge aclk);
    endtask

    task automatic bus_transaction(input logic op, input logic [7:0] cmd,
                                   input logic [7:0] wdata);
        send_tick(1'b1, op, cmd, wdata);
        settle_bus();
    endtask

    // only ever called with the engine idle and no result pending
    task automatic set_half_period(input logic [7:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Random ticks: a start on about one tick in start_odds. While a transaction runs those
    // starts are noise the engine must ignore; once it is idle the next start chains a
    // fresh transaction, so most ticks sit inside well-formed transfers.
    task automatic random_ticks(input int unsigned count, input int unsigned start_odds);
        repeat (count) begin
            send_tick($urandom_range(0, start_odds - 1) == 0, 1'(($urandom_range(0, 1))),
                      8'($urandom), 8'($urandom));
        end
        settle_bus();
    endtask

    // result side: bursts of ready broken by random stalls
    initial begin : result_sink
        int unsigned gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            gap = pick_gap();
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] hp_list [RANDOM_ROUNDS];
        hp_list = '{8'd1, 8'd0, 8'd3, 8'(($urandom_range(1, 4)))};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, half period still at its reset value ---
        bus_transaction(OP_WRITE, 8'h00, 8'hFF);
        pin_mode = PIN_HIGH;
        bus_transaction(OP_READ, 8'hFF, 8'h00);   // all-ones byte in

        // zero half period has to behave like one
        set_half_period(8'd0);
        pin_mode = PIN_LOW;
        bus_transaction(OP_READ, 8'h80, 8'hFF);   // all-zeros byte in
        pin_mode = PIN_RANDOM;
        bus_transaction(OP_WRITE, 8'h7F, 8'h80);

        // start held high: ignored while busy and on the done tick, taken right after
        set_half_period(8'd1);
        random_ticks(40, 1);

        // --- random rounds over several half periods, one of them without idling ---
        for (int unsigned i = 0; i < RANDOM_ROUNDS; i++) begin
            calm = (i == 2);
            set_half_period(hp_list[i]);
            random_ticks(ROUND_TICKS, 4);
        end
        calm = 1'b0;

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* three_wire_serial_master_unit.f */
rtl/core/tws_pkg.sv
rtl/core/tws_engine.sv
rtl/core/three_wire_serial_master_unit.sv
sim/tws_tick_checker.sv
sim/three_wire_serial_master_unit_tb.sv
